### rtl/tcprt_pkg.sv
package tcprt_pkg;

  // Default sizing, handed down from the top level
  localparam int unsigned DEPTH_DEF    = 32;
  localparam int unsigned TAG_BITS_DEF = 8;

  // Port field widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned RES_W      = 2;
  localparam int unsigned PRIO_W     = 4;
  localparam int unsigned CFG_W      = 6;

  // Priority range of a stored entry
  localparam logic [PRIO_W-1:0] PRIO_MIN = 4'd1;
  localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd10;
  localparam int unsigned       NUM_LVL  = 10;

  // Command codes carried on the slave tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  // Status of a held entry
  typedef enum logic [1:0] {
    ENT_WAIT = 2'd0,
    ENT_SERV = 2'd1,
    ENT_DONE = 2'd2
  } ent_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_CAP_LIMIT = 1'b0,
    REG_INTAKE    = 1'b1
  } reg_e;

  // Result status codes
  typedef enum logic [RES_W-1:0] {
    RES_OK    = 2'd0,
    RES_FULL  = 2'd1,
    RES_NONE  = 2'd2,
    RES_RANGE = 2'd3
  } res_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic pick;
    logic commit;
  } tcprt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
  } tcprt_sts_t;

endpackage

### rtl/two_class_priority_request_table_unit.sv
// Request table with two classes and ten priority levels. Each item on the
// slave stream is one command (insert, select, finish by tag, remove at
// position) and yields exactly one result item on the master stream. The
// result is loaded once the item has passed the controller states in order:
// in idle the accepting edge loads the request; in scan the compare of the
// request against every held entry is registered; in pick the first-match
// pick of the winner is registered; in commit the table is updated and the
// output register is loaded. It accepts only in idle, so it takes no new
// item before the last is done. The commit step waits while the output
// register still holds an untaken result; once it commits, the next item is
// accepted even if that result has not been taken yet. Configuration writes
// (capacity limit, intake closed) take effect at once and belong in idle time.
module two_class_priority_request_table_unit #(
  parameter int unsigned DEPTH    = tcprt_pkg::DEPTH_DEF,
  parameter int unsigned TAG_BITS = tcprt_pkg::TAG_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [tcprt_pkg::CFG_W-1:0]      cfg_data_i,
  // command items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // req_class[0], req_priority[4:1], req_tag[12:5], req_position[17:13]
  input  logic [tcprt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [tcprt_pkg::CMD_W-1:0]      s_axis_tuser,
  // result items
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_position[4:0], out_tag[12:5], out_priority[16:13], entry_count[22:17]
  output logic [tcprt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [tcprt_pkg::RES_W-1:0]      m_axis_tuser
);
  import tcprt_pkg::*;

  tcprt_cmd_t ctl;
  tcprt_sts_t sts;

  tcprt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  tcprt_dp #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

### rtl/tcprt_ctrl.sv
module tcprt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tcprt_pkg::tcprt_sts_t sts_i,
  output tcprt_pkg::tcprt_cmd_t ctl_o
);
  import tcprt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_COMMIT
  } state_e;

  state_e state_q;

  // Sequence one item: take it, scan the table, pick the winner, commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_SCAN;
        end
        S_SCAN:   state_q <= S_PICK;
        S_PICK:   state_q <= S_COMMIT;
        S_COMMIT: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  // Decode commands from the state
  assign in_ready_o   = (state_q == S_IDLE);
  assign ctl_o.load   = (state_q == S_IDLE) && in_valid_i;
  assign ctl_o.scan   = (state_q == S_SCAN);
  assign ctl_o.pick   = (state_q == S_PICK);
  assign ctl_o.commit = (state_q == S_COMMIT) && sts_i.out_free;

endmodule

### rtl/tcprt_dp.sv
module tcprt_dp #(
  parameter int unsigned DEPTH    = tcprt_pkg::DEPTH_DEF,
  parameter int unsigned TAG_BITS = tcprt_pkg::TAG_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [tcprt_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [tcprt_pkg::IN_DATA_W-1:0]  in_data_i,
  input  logic [tcprt_pkg::CMD_W-1:0]      in_user_i,
  input  tcprt_pkg::tcprt_cmd_t            ctl_i,
  output tcprt_pkg::tcprt_sts_t            sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tcprt_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic [tcprt_pkg::RES_W-1:0]      out_user_o
);
  import tcprt_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > CFG_W) ? CW : CFG_W;

  // Configuration
  logic [CFG_W-1:0] cap_limit_q;
  logic             intake_closed_q;

  // Entry table, one row of registers per position
  logic                cls_arr  [DEPTH];
  logic [PRIO_W-1:0]   prio_arr [DEPTH];
  logic [TAG_BITS-1:0] tag_arr  [DEPTH];
  ent_e                st_arr   [DEPTH];
  logic [CW-1:0]       count_q;

  // Current item
  cmd_e                cmd_q;
  logic                rcls_q;
  logic [PRIO_W-1:0]   rprio_q;
  logic [TAG_BITS-1:0] rtag_q;
  logic [4:0]          rpos_q;

  // Scan and pick results
  logic [DEPTH-1:0]   hit_d, hit_q;
  logic [NUM_LVL-1:0] lvl_d, lvl_q;
  logic [IW-1:0]      pidx_d, pidx_q;
  logic               pfound_d, pfound_q;

  // Output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [RES_W-1:0]      out_user_q;

  logic [PRIO_W-1:0] in_prio;
  logic [PRIO_W-1:0] in_prio_clamped;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_limit_q     <= 6'd20;
      intake_closed_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_CAP_LIMIT: cap_limit_q     <= cfg_data_i;
        REG_INTAKE:    intake_closed_q <= cfg_data_i[0];
        default:       cap_limit_q     <= cap_limit_q;
      endcase
    end
  end

  // Clamp the incoming priority into range
  assign in_prio = in_data_i[4:1];
  always_comb begin
    if (in_prio < PRIO_MIN) begin
      in_prio_clamped = PRIO_MIN;
    end else if (in_prio > PRIO_MAX) begin
      in_prio_clamped = PRIO_MAX;
    end else begin
      in_prio_clamped = in_prio;
    end
  end

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= cmd_e'(in_user_i);
      rcls_q  <= in_data_i[0];
      rprio_q <= in_prio_clamped;
      rtag_q  <= TAG_BITS'(in_data_i[12:5]);
      rpos_q  <= in_data_i[17:13];
    end
  end

  // Scan: compare every held entry against the request
  always_comb begin
    logic [DEPTH-1:0] elig;
    logic [DEPTH-1:0] fin;
    logic             held;
    lvl_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      held    = (CW'(i) < count_q);
      elig[i] = held && (st_arr[i] == ENT_WAIT) && (cls_arr[i] == rcls_q);
      fin[i]  = held && (st_arr[i] == ENT_SERV) && (tag_arr[i] == rtag_q);
    end
    for (int p = 0; p < NUM_LVL; p++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (elig[i] && (prio_arr[i] == PRIO_W'(p + 1))) lvl_d[p] = 1'b1;
      end
    end
    hit_d = (cmd_q == CMD_SELECT) ? elig : fin;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.scan) begin
      hit_q <= hit_d;
      lvl_q <= lvl_d;
    end
  end

  // Pick: for a select, the highest waiting level, then the oldest entry at that level; for a finish, the first match
  always_comb begin
    logic [PRIO_W-1:0] best_lvl;
    logic [DEPTH-1:0]  cand;
    logic [DEPTH-1:0]  first_oh;
    best_lvl = '0;
    for (int p = 0; p < NUM_LVL; p++) begin
      if (lvl_q[p]) best_lvl = PRIO_W'(p + 1);
    end
    for (int i = 0; i < DEPTH; i++) begin
      cand[i] = hit_q[i] && ((cmd_q != CMD_SELECT) || (prio_arr[i] == best_lvl));
    end
    first_oh = cand & (~cand + 1'b1);
    pidx_d   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_oh[i]) pidx_d = pidx_d | IW'(i);
    end
    pfound_d = |cand;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.pick) begin
      pidx_q   <= pidx_d;
      pfound_q <= pfound_d;
    end
  end

  // Commit: decide the result and the table update
  logic [IW-1:0]       ridx;
  logic [TAG_BITS-1:0] rd_tag;
  logic [PRIO_W-1:0]   rd_prio;
  logic [XW-1:0]       cap_x, cnt_x, pos_x;
  res_e                res;
  logic [4:0]          res_pos;
  logic [7:0]          res_tag;
  logic [PRIO_W-1:0]   res_prio;
  logic [CW-1:0]       count_d;
  logic                ins_we, shift_en, st_we;
  ent_e                st_val;

  assign ridx    = (cmd_q == CMD_REMOVE) ? IW'(rpos_q) : pidx_q;
  assign rd_tag  = tag_arr[ridx];
  assign rd_prio = prio_arr[ridx];
  assign cnt_x   = XW'(count_q);
  assign pos_x   = XW'(rpos_q);
  assign cap_x   = (XW'(cap_limit_q) < XW'(DEPTH)) ? XW'(cap_limit_q) : XW'(DEPTH);

  always_comb begin
    res      = RES_OK;
    res_pos  = '0;
    res_tag  = '0;
    res_prio = '0;
    count_d  = count_q;
    ins_we   = 1'b0;
    shift_en = 1'b0;
    st_we    = 1'b0;
    st_val   = ENT_SERV;
    unique case (cmd_q)
      CMD_INSERT: begin
        if (intake_closed_q || (cnt_x >= cap_x)) begin
          res = RES_FULL;
        end else begin
          res_pos  = 5'(count_q);
          res_tag  = 8'(rtag_q);
          res_prio = rprio_q;
          count_d  = count_q + 1'b1;
          ins_we   = 1'b1;
        end
      end
      CMD_SELECT, CMD_FINISH: begin
        if (!pfound_q) begin
          res = RES_NONE;
        end else begin
          res_pos  = 5'(pidx_q);
          res_tag  = 8'(rd_tag);
          res_prio = rd_prio;
          st_we    = 1'b1;
          st_val   = (cmd_q == CMD_SELECT) ? ENT_SERV : ENT_DONE;
        end
      end
      CMD_REMOVE: begin
        if (pos_x >= cnt_x) begin
          res = RES_RANGE;
        end else begin
          res_pos  = rpos_q;
          res_tag  = 8'(rd_tag);
          res_prio = rd_prio;
          count_d  = count_q - 1'b1;
          shift_en = 1'b1;
        end
      end
      default: res = RES_NONE;
    endcase
  end

  // Update the entry table
  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      if (ins_we) begin
        cls_arr[IW'(count_q)]  <= rcls_q;
        prio_arr[IW'(count_q)] <= rprio_q;
        tag_arr[IW'(count_q)]  <= rtag_q;
        st_arr[IW'(count_q)]   <= ENT_WAIT;
      end
      if (st_we) begin
        st_arr[pidx_q] <= st_val;
      end
      if (shift_en) begin
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (i >= int'(rpos_q)) begin
            cls_arr[i]  <= cls_arr[i+1];
            prio_arr[i] <= prio_arr[i+1];
            tag_arr[i]  <= tag_arr[i+1];
            st_arr[i]   <= st_arr[i+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.commit) begin
      count_q <= count_d;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      out_data_q <= {1'b0, 6'(count_d), res_prio, res_tag, res_pos};
      out_user_q <= res;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_user_o     = out_user_q;

endmodule

### rtl/tcprt_checker.sv
module tcprt_checker #(
  parameter int unsigned DEPTH = tcprt_pkg::DEPTH_DEF
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [tcprt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [tcprt_pkg::RES_W-1:0]      m_axis_tuser
);
  import tcprt_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A failed command reports no position, tag or priority
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != RES_OK) |-> (m_axis_tdata[16:0] == 17'd0))
    else $error("failed command carries entry fields");

  // Every successful result names an entry with a priority in range
  a_ok_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == RES_OK) |->
      (m_axis_tdata[16:13] >= PRIO_MIN) && (m_axis_tdata[16:13] <= PRIO_MAX))
    else $error("successful result with priority out of range");

  // Entry count never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (int'(m_axis_tdata[22:17]) <= int'(DEPTH)))
    else $error("entry count beyond table depth");

endmodule

bind two_class_priority_request_table_unit tcprt_checker #(.DEPTH(DEPTH)) u_tcprt_checker (.*);
